// ----- hdl/twv_pkg.sv -----
// Shared types and constants for the trapped water volume block.
`timescale 1ns / 1ps
`default_nettype none

package twv_pkg;

   // Fixed field widths of the item channels
   localparam int HeightInW = 32;
   localparam int WaterW    = 42;

   // One bar of the profile
   typedef struct packed {
      logic [HeightInW-1:0] height;
      logic                 last_bar;
   } req_type;

   // One result of a finished profile
   typedef struct packed {
      logic [WaterW-1:0] total_water;
      logic              overflow;
   } rsp_type;

   // Controller states, one-hot
   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_BACK  = 5'b00010,
      ST_GAP   = 5'b00100,
      ST_FWD   = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_we;   // store the incoming bar
      logic drop;      // store full, bar dropped
      logic rd_en;     // issue a store read for a pass
      logic rd_fwd;    // read belongs to the forward pass
      logic capture;   // load the result register and clear the sums
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic pipe_busy; // reads or sums still in flight
      logic rsp_free;  // result register can take a new item
   } sts_type;

endpackage

`default_nettype wire

// ----- hdl/trapped_water_volume_core.sv -----
// Top level of the trapped water volume block: controller plus datapath.
//
// Usage:
//   Bars enter on the req_ channel (valid/ready), one per cycle, the final bar
//   of a profile flagged by last_bar. Up to MAX_BARS bars are stored; later
//   bars of the same profile are dropped and the overflow flag is set.
//   After the last bar, req_ready drops while a backward pass over the stored
//   bars builds suffix maxima and a forward pass sums the trapped water. The
//   two store passes run one read per cycle through a single read port per
//   memory. req_ready returns together with rsp_valid. Loading runs at one
//   bar per cycle while req_ready is high.
//   The result sits in an output register: a stalled receiver does not block
//   loading of the next profile, only the hand-off of its result.
//   Reset clears the controller, sums and flags; the stores need no clearing
//   because only entries written for the current profile are read.
`timescale 1ns / 1ps
`default_nettype none

module trapped_water_volume_core #(
   parameter int MAX_BARS    = 1024,
   parameter int HEIGHT_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire twv_pkg::req_type req,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output twv_pkg::rsp_type      rsp
);
   import twv_pkg::*;

   localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

   cmd_type       cmd;
   sts_type       sts;
   logic [AW-1:0] load_addr;
   logic [AW-1:0] rd_addr;

   twv_ctrl #(.MAX_BARS(MAX_BARS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_bar (req.last_bar),
      .req_ready    (req_ready),
      .cmd          (cmd),
      .sts          (sts),
      .load_addr    (load_addr),
      .rd_addr      (rd_addr)
   );

   twv_datapath #(.MAX_BARS(MAX_BARS), .HEIGHT_BITS(HEIGHT_BITS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_height (req.height),
      .cmd        (cmd),
      .sts        (sts),
      .load_addr  (load_addr),
      .rd_addr    (rd_addr),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire

// ----- hdl/twv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module twv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port, then registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ----- hdl/twv_ctrl.sv -----
// Controller: load, backward pass, forward pass and result hand-off sequencing.
`timescale 1ns / 1ps
`default_nettype none

module twv_ctrl #(
   parameter int MAX_BARS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last_bar,
   output logic                       req_ready,
   output twv_pkg::cmd_type           cmd,
   input  wire twv_pkg::sts_type      sts,
   output logic [((MAX_BARS > 1) ? $clog2(MAX_BARS) : 1)-1:0] load_addr,
   output logic [((MAX_BARS > 1) ? $clog2(MAX_BARS) : 1)-1:0] rd_addr
);
   import twv_pkg::*;

   localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int CW = $clog2(MAX_BARS + 1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           accept;
   logic           room;
   logic [CW-1:0]  count_nx;
   logic [CW-1:0]  count_nx_m1;
   logic [CW-1:0]  count_m1;

   assign req_ready   = (state_ff == ST_LOAD);
   assign accept      = req_valid & req_ready;
   assign room        = (count_ff < CW'(MAX_BARS));
   assign count_nx    = count_ff + CW'(room);
   assign count_nx_m1 = count_nx - CW'(1);
   assign count_m1    = count_ff - CW'(1);
   assign load_addr   = count_ff[AW-1:0];
   assign rd_addr     = idx_ff;

   // Next state, counters and commands
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               cmd.load_we = room;
               cmd.drop    = ~room;
               count_in    = count_nx;
               if (req_last_bar) begin
                  idx_in   = count_nx_m1[AW-1:0];
                  state_in = ST_BACK;
               end
            end
         end
         ST_BACK: begin
            // walk from the last bar down to the first
            cmd.rd_en = 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_GAP;
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end
         ST_GAP: begin
            // let the final suffix write land before reading it back
            if (!sts.pipe_busy) begin
               idx_in   = '0;
               state_in = ST_FWD;
            end
         end
         ST_FWD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_fwd = 1'b1;
            if (idx_ff == count_m1[AW-1:0]) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            // hand off once the sum is final and the result slot is free
            if (!sts.pipe_busy && sts.rsp_free) begin
               cmd.capture = 1'b1;
               count_in    = '0;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/twv_datapath.sv -----
// Datapath: bar and suffix-max stores, pass pipeline, water sum and result register.
`timescale 1ns / 1ps
`default_nettype none

module twv_datapath #(
   parameter int MAX_BARS    = 1024,
   parameter int HEIGHT_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [twv_pkg::HeightInW-1:0] req_height,
   input  wire twv_pkg::cmd_type      cmd,
   output twv_pkg::sts_type           sts,
   input  wire logic [((MAX_BARS > 1) ? $clog2(MAX_BARS) : 1)-1:0] load_addr,
   input  wire logic [((MAX_BARS > 1) ? $clog2(MAX_BARS) : 1)-1:0] rd_addr,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output twv_pkg::rsp_type           rsp
);
   import twv_pkg::*;

   localparam int AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
   localparam int SW = (HEIGHT_BITS < HeightInW) ? HEIGHT_BITS : HeightInW;

   logic [SW-1:0]     h_q, s_q;
   logic              rd_v_ff;
   logic              rd_fwd_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic [SW-1:0]     best_ff, best_in;
   logic [SW-1:0]     left_ff, left_in;
   logic [SW-1:0]     level;
   logic              w_v_ff;
   logic [SW-1:0]     w_ff;
   logic [WaterW-1:0] sum_ff;
   logic [WaterW:0]   sum_wide;
   logic [WaterW-1:0] sum_in;
   logic              ovf_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   logic              suf_we;

   twv_ram #(.WIDTH(SW), .DEPTH(MAX_BARS)) u_height_ram (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (load_addr),
      .wdata (req_height[SW-1:0]),
      .raddr (rd_addr),
      .rdata (h_q)
   );

   twv_ram #(.WIDTH(SW), .DEPTH(MAX_BARS)) u_suffix_ram (
      .clock (clock),
      .we    (suf_we),
      .waddr (rd_addr_ff),
      .wdata (best_in),
      .raddr (rd_addr),
      .rdata (s_q)
   );

   // Backward pass: running max from the end, written back as suffix max
   assign best_in = (h_q > best_ff) ? h_q : best_ff;
   assign suf_we  = rd_v_ff & ~rd_fwd_ff;

   // Forward pass: prefix max, water level is the lower of the two maxima
   assign left_in = (h_q > left_ff) ? h_q : left_ff;
   assign level   = (left_in < s_q) ? left_in : s_q;

   // Saturating accumulate
   assign sum_wide = {1'b0, sum_ff} + (WaterW+1)'(w_ff);
   assign sum_in   = sum_wide[WaterW] ? {WaterW{1'b1}} : sum_wide[WaterW-1:0];

   assign sts.pipe_busy = rd_v_ff | w_v_ff;
   assign sts.rsp_free  = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;

   // Control and running state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff      <= 1'b0;
         w_v_ff       <= 1'b0;
         best_ff      <= '0;
         left_ff      <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.rd_en;
         w_v_ff  <= rd_v_ff & rd_fwd_ff;
         if (suf_we) begin
            best_ff <= best_in;
         end
         if (rd_v_ff && rd_fwd_ff) begin
            left_ff <= left_in;
         end
         if (w_v_ff) begin
            sum_ff <= sum_in;
         end
         if (cmd.drop) begin
            ovf_ff <= 1'b1;
         end
         // clear for the next profile once the result is taken over
         if (cmd.capture) begin
            best_ff      <= '0;
            left_ff      <= '0;
            sum_ff       <= '0;
            ovf_ff       <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_fwd_ff  <= cmd.rd_fwd;
      rd_addr_ff <= rd_addr;
      w_ff       <= level - h_q;
      if (cmd.capture) begin
         rsp_ff.total_water <= sum_ff;
         rsp_ff.overflow    <= ovf_ff;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/twv_checker.sv -----
// Port-level checks for the trapped water volume block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module twv_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire twv_pkg::req_type req,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire twv_pkg::rsp_type rsp
);
   import twv_pkg::*;

   // A stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
      else $error("result item dropped or changed while stalled");

   // No result item right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown right after reset");

   // The passes block loading right after a last bar
   a_passes_block: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req.last_bar) |=> !req_ready)
      else $error("bar taken during the store passes");

   // A new result only follows a pass phase, never straight out of loading
   a_rsp_after_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result item appeared while loading");

endmodule

bind trapped_water_volume_core twv_checker u_twv_checker (.*);

`default_nettype wire

// ----- dv/trapped_water_volume_core_test.sv -----
// Testbench for trapped_water_volume_core: bar profiles driven in, totals checked by a scoreboard.
`timescale 1ns / 1ps

module trapped_water_volume_core_test;
   import twv_pkg::*;

   localparam int MaxBars     = 1024;
   localparam int HeightBits  = 32;
   localparam int RandomBars  = 550;
   localparam int CalmBars    = 150;
   localparam int CycleLimit  = 400000;
   localparam logic [WaterW:0] WaterLimit = {1'b0, {WaterW{1'b1}}};

   // Height patterns for random profiles
   typedef enum int {
      HT_FULL,
      HT_SMALL,
      HT_EXTREME,
      HT_HIGH
   } height_style_type;

   // Expected totals per profile; bars are kept until the last one arrives
   class water_board;
      logic [HeightInW-1:0] bars[$];
      bit                   dropped;
      rsp_type              pending[$];
      int                   errors;

      // Backward pass for suffix maxima, then forward pass summing the water
      function logic [WaterW-1:0] profile_water();
         logic [HeightInW-1:0] right_max[$];
         logic [HeightInW-1:0] best;
         logic [HeightInW-1:0] left_max;
         logic [HeightInW-1:0] level;
         logic [WaterW:0]      sum;
         right_max = bars;
         best = '0;
         for (int k = bars.size() - 1; k >= 0; k--) begin
            if (bars[k] > best) best = bars[k];
            right_max[k] = best;
         end
         left_max = '0;
         sum = '0;
         for (int k = 0; k < bars.size(); k++) begin
            if (bars[k] > left_max) left_max = bars[k];
            level = (left_max < right_max[k]) ? left_max : right_max[k];
            sum = sum + (level - bars[k]);
            if (sum > WaterLimit) sum = WaterLimit;
         end
         return sum[WaterW-1:0];
      endfunction

      // Store an accepted bar; close the profile on the last one
      function void note_bar(req_type b);
         rsp_type want;
         if (bars.size() < MaxBars) bars.push_back(b.height);
         else dropped = 1'b1;
         if (b.last_bar) begin
            want.total_water = profile_water();
            want.overflow    = dropped;
            pending.push_back(want);
            bars.delete();
            dropped = 1'b0;
         end
      endfunction

      // Compare an accepted result with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result total_water=%0d overflow=%0b",
                     $time, got.total_water, got.overflow);
            return;
         end
         want = pending.pop_front();
         if (got.total_water !== want.total_water) begin
            errors++;
            $display("%0t: total_water expected %0d actual %0d",
                     $time, want.total_water, got.total_water);
         end
         if (got.overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow expected %0b actual %0b",
                     $time, want.overflow, got.overflow);
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   water_board           board;
   bit                   sender_idle   = 1'b1;
   bit                   receiver_idle = 1'b1;
   int                   cycle_count   = 0;
   logic [HeightInW-1:0] plan[$];

   trapped_water_volume_core #(
      .MAX_BARS   (MaxBars),
      .HEIGHT_BITS(HeightBits)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req      (req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

   // Free-running clock
   initial begin
      forever #10 clock = ~clock;
   end

   // Watch both channels at every edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_bar(req);
         if (rsp_valid && rsp_ready) board.check_result(rsp);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: stall in random bursts while idling is on
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (receiver_idle && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Offer one bar and hold it until accepted
   task automatic send_bar(input logic [HeightInW-1:0] h, input logic last);
      req_type item;
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      item.height   = h;
      item.last_bar = last;
      req_valid <= 1'b1;
      req       <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Send the planned heights as one profile
   task automatic send_plan();
      for (int k = 0; k < plan.size(); k++) send_bar(plan[k], k == plan.size() - 1);
   endtask

   function automatic logic [HeightInW-1:0] pick_height(height_style_type style);
      case (style)
         HT_FULL:    return $urandom;
         HT_SMALL:   return $urandom_range(0, 9);
         HT_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
         default:    return 32'hFFFF_FF00 | $urandom_range(0, 255);
      endcase
   endfunction

   // Random profile of n bars in the given pattern
   task automatic send_random_profile(input int n, input height_style_type style);
      for (int k = 0; k < n; k++) send_bar(pick_height(style), k == n - 1);
   endtask

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 7) return $urandom_range(1, 8);
      if (roll < 9) return $urandom_range(9, 40);
      return $urandom_range(41, 200);
   endfunction

   // Hold the sender until every expected result has come
   task automatic wait_results();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int               random_bars;
      int               n;
      bit               paused;
      height_style_type style;

      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: single bars at both extremes, a deep valley, a classic profile, a mixed one
      plan = '{32'h0000_0000};
      send_plan();
      plan = '{32'hFFFF_FFFF};
      send_plan();
      plan = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      send_plan();
      plan = '{0, 1, 0, 2, 1, 0, 1, 3, 2, 1, 2, 1};
      send_plan();
      plan = '{7, 1, 32'hFFFF_FFFF, 4};
      send_plan();
      wait_results();

      // Fill the store with the deepest possible basin, then overrun it so
      // that the last bar is dropped too
      plan.delete();
      plan.push_back('1);
      for (int k = 1; k < MaxBars - 1; k++) plan.push_back('0);
      plan.push_back('1);
      plan.push_back('1);
      plan.push_back('0);
      send_plan();

      // Random profiles, mostly short
      random_bars = 0;
      paused = 1'b0;
      while (random_bars < RandomBars) begin
         if (random_bars >= RandomBars - CalmBars) begin
            sender_idle   = 1'b0;
            receiver_idle = 1'b0;
         end
         n = pick_length();
         style = height_style_type'($urandom_range(0, 3));
         send_random_profile(n, style);
         random_bars += n;
         if (!paused && random_bars > RandomBars / 2) begin
            wait_results();
            paused = 1'b1;
         end
      end

      // Drain and let the block settle
      wait_results();
      repeat (2 * MaxBars + 20) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
